>>> sv/sts_pkg.sv
// shared constants, types and the per-pixel sobel sharpen function
// for the sobel threshold sharpen block; no dependencies
`default_nettype none

package sts_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 12;
    localparam int POS_W      = 11;
    localparam int CFG_W      = 12;

    typedef logic [23:0]      t_pix;
    typedef logic [8:0][23:0] t_win;
    typedef logic [3:0]       t_res_mask;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_EDGE_THRESHOLD  = 2'd2,
        REG_BRIGHTNESS_STEP = 2'd3
    } t_cfg_reg;

    // window index = col*3 + row, col 0 is leftmost, row 0 is top
    function automatic t_pix sharpen(input t_win w, input logic [7:0] thr,
                                     input logic signed [8:0] step);
        t_pix               res;
        logic [9:0]         gx_p;
        logic [9:0]         gx_n;
        logic [9:0]         gy_p;
        logic [9:0]         gy_n;
        logic [9:0]         ax;
        logic [9:0]         ay;
        logic [7:0]         mag;
        logic [7:0]         c;
        logic signed [10:0] sum;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            gx_p = {2'b0, w[6][8*ch +: 8]} + {1'b0, w[7][8*ch +: 8], 1'b0}
                 + {2'b0, w[8][8*ch +: 8]};
            gx_n = {2'b0, w[0][8*ch +: 8]} + {1'b0, w[1][8*ch +: 8], 1'b0}
                 + {2'b0, w[2][8*ch +: 8]};
            gy_p = {2'b0, w[2][8*ch +: 8]} + {1'b0, w[5][8*ch +: 8], 1'b0}
                 + {2'b0, w[8][8*ch +: 8]};
            gy_n = {2'b0, w[0][8*ch +: 8]} + {1'b0, w[3][8*ch +: 8], 1'b0}
                 + {2'b0, w[6][8*ch +: 8]};
            ax   = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
            ay   = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);
            mag  = {1'b0, ax[9:3]} + {1'b0, ay[9:3]};
            c    = w[4][8*ch +: 8];
            if ({1'b0, mag} > {thr, 1'b0}) begin
                sum = $signed({3'b0, c}) + {{2{step[8]}}, step};
                if (sum < 0) begin
                    c = 8'd0;
                end else if (sum > 11'sd255) begin
                    c = 8'd255;
                end else begin
                    c = sum[7:0];
                end
            end
            res[8*ch +: 8] = c;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/sobel_threshold_sharpen.sv
// top level of the 3x3 sobel edge sharpener for raster rgb pixels
// depends on sts_pkg for sizes, types and the sharpen function
`default_nettype none

// usage
//   input channel: i_valid / o_stall with one rgb pixel per transaction,
//   pixels in raster order, frame size taken from image_width/image_height
//   output channel: o_valid / i_stall, one output pixel per transaction with
//   its row and column; o_last_of_run marks the final result of an input
//   path: an input is registered in the line store read stage, and its
//   results are registered in the result stage, which offers them
//   throughput: one input per cycle while each input causes at most one
//   result and i_stall is low; the result stage drains one result per cycle
//   while i_stall is low, so an input at the end of a row (two results) or
//   in the last row (up to four) holds the input side while extras drain
//   row 0 causes no results; the last row is flushed as it arrives
//   reset: frame position goes to row 0, column 0, both stages empty,
//   registers back to 640 x 480, threshold 32, step 0; line stores are not
//   cleared and need no clearing pass
//   receiver stall: the result stage holds its payload, the read stage
//   fills, then o_stall rises; nothing is dropped
//   writing image_width or image_height restarts the frame at row 0

module sobel_threshold_sharpen (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [sts_pkg::CFG_W-1:0]  i_cfg_data,
    // pixel input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_blue_in,
    input  wire logic [7:0]                 i_green_in,
    input  wire logic [7:0]                 i_red_in,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [7:0]                      o_blue_out,
    output logic [7:0]                      o_green_out,
    output logic [7:0]                      o_red_out,
    output logic [sts_pkg::POS_W-1:0]       o_out_row,
    output logic [sts_pkg::POS_W-1:0]       o_out_col,
    output logic                            o_last_of_run
);
    import sts_pkg::*;

    // configuration registers
    logic [SIZE_W-1:0]       r_width;
    logic [SIZE_W-1:0]       r_height;
    logic [7:0]              r_thr;
    logic signed [8:0]       r_step;
    logic [SIZE_W-1:0]       w_eff;
    logic [SIZE_W-1:0]       h_eff;

    // frame position of the next input
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic                    col_last;
    logic                    row_last;

    // line stores, two rows above the current one
    t_pix                    line_above [MAX_WIDTH];
    t_pix                    line_two_above [MAX_WIDTH];

    // read stage: input pixel plus the column from the line stores
    logic                    r_s1_valid;
    t_pix                    r_s1_px;
    t_pix                    r_s1_top;
    t_pix                    r_s1_mid;
    logic [COL_W-1:0]        r_s1_x;
    logic [ROW_W-1:0]        r_s1_y;
    logic                    r_s1_xlast;
    logic                    r_s1_ylast;

    // two older window columns and the previous pixel
    t_pix                    r_win [6];
    t_pix                    r_prev;

    // result stage: up to four results of one input
    t_res_mask               r_s2_mask;
    t_pix                    r_s2_center;
    t_pix                    r_s2_mid;
    t_pix                    r_s2_prev;
    t_pix                    r_s2_px;
    logic [COL_W-1:0]        r_s2_x;
    logic [ROW_W-1:0]        r_s2_y;

    logic                    in_acc;
    logic                    out_acc;
    logic                    s2_single;
    logic                    s2_free;
    logic                    s1_move;
    t_res_mask               low_bit;
    t_res_mask               n_s2_mask;
    t_win                    cur_win;
    t_pix                    n_s2_center;
    logic                    s1_inner;
    t_pix                    sel_pix;
    logic [COL_W-1:0]        sel_col;
    logic [ROW_W-1:0]        sel_row;

    // effective frame size, saturated to the supported range
    always_comb begin
        if (r_width < SIZE_W'(3)) begin
            w_eff = SIZE_W'(3);
        end else if (r_width > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < SIZE_W'(3)) begin
            h_eff = SIZE_W'(3);
        end else if (r_height > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign col_last = (SIZE_W'(r_col) == w_eff - SIZE_W'(1));
    assign row_last = (SIZE_W'(r_row) == h_eff - SIZE_W'(1));

    // handshake: the result stage frees when empty or on its last result
    assign s2_single = (r_s2_mask & (r_s2_mask - t_res_mask'(1))) == '0;
    assign o_valid   = (r_s2_mask != '0);
    assign out_acc   = o_valid && !i_stall;
    assign s2_free   = !o_valid || (out_acc && s2_single);
    assign s1_move   = r_s1_valid && s2_free;
    assign o_stall   = r_s1_valid && !s2_free;
    assign in_acc    = i_valid && !o_stall;

    // configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(640);
            r_height <= SIZE_W'(480);
            r_thr    <= 8'd32;
            r_step   <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data[SIZE_W-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data[SIZE_W-1:0];
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    REG_EDGE_THRESHOLD: begin
                        r_thr <= i_cfg_data[7:0];
                    end
                    REG_BRIGHTNESS_STEP: begin
                        r_step <= $signed(i_cfg_data[8:0]);
                    end
                    default: begin
                    end
                endcase
            end else if (in_acc) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // line stores: read at the input column, the row above moves down
    // in the following cycle from the registered read data
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_top            <= line_two_above[r_col];
            r_s1_mid            <= line_above[r_col];
            line_above[r_col]   <= {i_red_in, i_green_in, i_blue_in};
        end
        if (r_s1_valid) begin
            line_two_above[r_s1_x] <= r_s1_mid;
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px    <= {i_red_in, i_green_in, i_blue_in};
            r_s1_x     <= r_col;
            r_s1_y     <= r_row;
            r_s1_xlast <= col_last;
            r_s1_ylast <= row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // 3x3 window for the item in the read stage
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            cur_win[i] = r_win[i];
        end
        cur_win[6] = r_s1_top;
        cur_win[7] = r_s1_mid;
        cur_win[8] = r_s1_px;
    end

    // interior pixels get the sobel test, border pixels pass
    assign s1_inner    = (r_s1_y >= ROW_W'(2)) && (r_s1_x >= COL_W'(2));
    assign n_s2_center = s1_inner ? sharpen(cur_win, r_thr, r_step) : r_win[4];

    // which results this item causes, in output order:
    // center above-left, right border above, bottom row left, bottom corner
    always_comb begin
        n_s2_mask[0] = (r_s1_y != '0) && (r_s1_x != '0);
        n_s2_mask[1] = (r_s1_y != '0) && r_s1_xlast;
        n_s2_mask[2] = r_s1_ylast && (r_s1_x != '0);
        n_s2_mask[3] = r_s1_ylast && r_s1_xlast;
    end

    // window columns and previous pixel advance as an item leaves the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_prev <= '0;
        end else if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= r_win[i+3];
            end
            r_win[3] <= r_s1_top;
            r_win[4] <= r_s1_mid;
            r_win[5] <= r_s1_px;
            r_prev   <= r_s1_px;
        end
    end

    // result stage
    assign low_bit = r_s2_mask & (~r_s2_mask + t_res_mask'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= '0;
        end else if (s1_move) begin
            r_s2_mask <= n_s2_mask;
        end else if (out_acc) begin
            r_s2_mask <= r_s2_mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_center <= n_s2_center;
            r_s2_mid    <= r_s1_mid;
            r_s2_prev   <= r_prev;
            r_s2_px     <= r_s1_px;
            r_s2_x      <= r_s1_x;
            r_s2_y      <= r_s1_y;
        end
    end

    // pick the lowest pending result
    always_comb begin
        priority if (r_s2_mask[0]) begin
            sel_pix = r_s2_center;
            sel_row = r_s2_y - ROW_W'(1);
            sel_col = r_s2_x - COL_W'(1);
        end else if (r_s2_mask[1]) begin
            sel_pix = r_s2_mid;
            sel_row = r_s2_y - ROW_W'(1);
            sel_col = r_s2_x;
        end else if (r_s2_mask[2]) begin
            sel_pix = r_s2_prev;
            sel_row = r_s2_y;
            sel_col = r_s2_x - COL_W'(1);
        end else begin
            sel_pix = r_s2_px;
            sel_row = r_s2_y;
            sel_col = r_s2_x;
        end
    end

    assign o_blue_out    = sel_pix[7:0];
    assign o_green_out   = sel_pix[15:8];
    assign o_red_out     = sel_pix[23:16];
    assign o_out_row     = POS_W'(sel_row);
    assign o_out_col     = POS_W'(sel_col);
    assign o_last_of_run = s2_single;

`ifndef SYNTHESIS
    // an accepted input lands in the read stage
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted pixel missing from read stage");

    // a result that is not the last of its run is followed by another one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_last_of_run |=> o_valid)
        else $error("result run ended early");

    // the frame position stays inside the frame
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SIZE_W'(r_col) < w_eff)
        else $error("column counter outside frame");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SIZE_W'(r_row) < h_eff)
        else $error("row counter outside frame");

    // input is held back only while the read stage cannot empty
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && o_valid)
        else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire

>>> bench/tb_sobel_threshold_sharpen.sv
// self-checking bench for sobel_threshold_sharpen: raster pixel frames, register writes,
// a bit-true prediction of every output pixel and a field-by-field compare
// depends on sts_pkg and sobel_threshold_sharpen
`default_nettype none

module tb_sobel_threshold_sharpen;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 8;
    localparam int LINE_DEPTH   = sts_pkg::MAX_WIDTH;
    // two pipeline stages plus up to three extra results per input
    localparam int DRAIN_PAD    = 8;
    localparam int END_WAIT     = 20000;
    localparam int RANDOM_ITEMS = 170;
    // far beyond the slowest correct run: every result behind a long stall
    localparam int LIMIT_TIME   = 3_000_000 * 2 * CLK_HALF;

    typedef struct packed {
        logic [7:0]              blue;
        logic [7:0]              green;
        logic [7:0]              red;
        logic [sts_pkg::POS_W-1:0] row;
        logic [sts_pkg::POS_W-1:0] col;
        logic                    last;
    } t_out_pixel;

    // pixel content of a frame
    typedef enum int {
        PAT_NOISE,   // every bit random
        PAT_BINARY,  // channels at 0 or 255, strong edges
        PAT_SMOOTH,  // slow ramp, mostly below threshold
        PAT_BARS     // black column, mid column, then white
    } t_pattern;

    // dut ports
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [1:0]                  i_cfg_index = '0;
    logic [sts_pkg::CFG_W-1:0]   i_cfg_data  = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_stall;
    logic [7:0]                  i_blue_in   = '0;
    logic [7:0]                  i_green_in  = '0;
    logic [7:0]                  i_red_in    = '0;
    logic                        o_valid;
    logic                        i_stall     = 1'b0;
    logic [7:0]                  o_blue_out;
    logic [7:0]                  o_green_out;
    logic [7:0]                  o_red_out;
    logic [sts_pkg::POS_W-1:0]   o_out_row;
    logic [sts_pkg::POS_W-1:0]   o_out_col;
    logic                        o_last_of_run;

    // predictor state, a private copy of what the block holds
    logic [23:0]       line_store_above     [LINE_DEPTH];
    logic [23:0]       line_store_two_above [LINE_DEPTH];
    logic [23:0]       window_cols [6];  // [0..2] column x-2 top..bottom, [3..5] column x-1
    logic [23:0]       prev_pixel   = '0;
    int                frame_row    = 0;
    int                frame_col    = 0;
    logic [11:0]       cfg_width    = 12'd640;
    logic [11:0]       cfg_height   = 12'd480;
    logic [7:0]        cfg_threshold = 8'd32;
    logic signed [8:0] cfg_step     = '0;

    t_out_pixel expected_pixels[$];
    int         error_count = 0;
    int         pixels_sent = 0;
    bit         in_quiet    = 1'b0;  // no gaps on the pixel side
    bit         out_quiet   = 1'b0;  // no stalls on the result side
    int         stall_left  = 0;

    sobel_threshold_sharpen u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_blue_in     (i_blue_in),
        .i_green_in    (i_green_in),
        .i_red_in      (i_red_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_blue_out    (o_blue_out),
        .o_green_out   (o_green_out),
        .o_red_out     (o_red_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // frame sizes outside 3..2048 are clamped when used
    function automatic int clamp_size(input logic [11:0] v);
        if (v < 12'd3) begin
            return 3;
        end
        if (v > 12'(sts_pkg::MAX_WIDTH)) begin
            return sts_pkg::MAX_WIDTH;
        end
        return int'(v);
    endfunction

    // per channel sobel magnitude against twice the threshold, then clamped step
    // nb index is col*3 + row, col 0 left, row 0 top
    function automatic logic [23:0] sharpen_pixel(input logic [8:0][23:0] nb);
        int          a [9];
        int          gx;
        int          gy;
        int          mag;
        int          c;
        logic [23:0] res;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                a[k] = int'(nb[k][8*ch +: 8]);
            end
            gx  = (a[6] + 2 * a[7] + a[8]) - (a[0] + 2 * a[1] + a[2]);
            gy  = (a[2] + 2 * a[5] + a[8]) - (a[0] + 2 * a[3] + a[6]);
            mag = (gx < 0 ? -gx : gx) / 8 + (gy < 0 ? -gy : gy) / 8;
            c   = a[4];
            if (mag > 2 * int'(cfg_threshold)) begin
                c = c + int'(cfg_step);
                if (c < 0) begin
                    c = 0;
                end else if (c > 255) begin
                    c = 255;
                end
            end
            res[8*ch +: 8] = 8'(c);
        end
        return res;
    endfunction

    function automatic t_out_pixel make_result(input logic [23:0] px, input int y, input int x);
        t_out_pixel r;
        r.blue  = px[7:0];
        r.green = px[15:8];
        r.red   = px[23:16];
        r.row   = sts_pkg::POS_W'(y);
        r.col   = sts_pkg::POS_W'(x);
        r.last  = 1'b0;
        return r;
    endfunction

    // one accepted pixel: queue the output pixels it releases, then advance the state
    task automatic predict_sharpened_pixels(input logic [23:0] px);
        int               w;
        int               h;
        int               x;
        int               y;
        int               xi;
        bit               inner;
        logic [8:0][23:0] nb;
        t_out_pixel       run[$];
        w  = clamp_size(cfg_width);
        h  = clamp_size(cfg_height);
        x  = frame_col;
        y  = frame_row;
        xi = x % LINE_DEPTH;
        for (int i = 0; i < 6; i++) begin
            nb[i] = window_cols[i];
        end
        nb[6] = line_store_two_above[xi];
        nb[7] = line_store_above[xi];
        nb[8] = px;

        // center of the window, sharpened unless on the border
        if (y >= 1 && x >= 1) begin
            inner = (y >= 2) && (y <= h - 1) && (x >= 2) && (x <= w - 1);
            run.insert(run.size(),
                       make_result(inner ? sharpen_pixel(nb) : nb[4], y - 1, x - 1));
        end
        // right border of the row above
        if (y >= 1 && x == w - 1) begin
            run.insert(run.size(), make_result(nb[7], y - 1, x));
        end
        // last row is flushed as it arrives
        if (y == h - 1 && x >= 1) begin
            run.insert(run.size(), make_result(prev_pixel, y, x - 1));
        end
        if (y == h - 1 && x == w - 1) begin
            run.insert(run.size(), make_result(px, y, x));
        end
        if (run.size() > 0) begin
            run[run.size() - 1].last = 1'b1;
        end
        foreach (run[i]) begin
            expected_pixels.insert(expected_pixels.size(), run[i]);
        end

        for (int i = 0; i < 3; i++) begin
            window_cols[i]     = window_cols[i + 3];
            window_cols[i + 3] = nb[6 + i];
        end
        line_store_two_above[xi] = nb[7];
        line_store_above[xi]     = px;
        prev_pixel               = px;
        frame_col                = x + 1;
        if (frame_col >= w) begin
            frame_col = 0;
            frame_row = y + 1;
            if (frame_row >= h) begin
                frame_row = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // register write, only while the block is idle; a size write restarts the frame
    task automatic write_register(input sts_pkg::t_cfg_reg idx, input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            sts_pkg::REG_IMAGE_WIDTH: begin
                cfg_width = value;
                frame_row = 0;
                frame_col = 0;
            end
            sts_pkg::REG_IMAGE_HEIGHT: begin
                cfg_height = value;
                frame_row  = 0;
                frame_col  = 0;
            end
            sts_pkg::REG_EDGE_THRESHOLD: begin
                cfg_threshold = value[7:0];
            end
            sts_pkg::REG_BRIGHTNESS_STEP: begin
                cfg_step = value[8:0];
            end
            default: begin
            end
        endcase
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (in_quiet || roll < 70) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // one pixel transaction; valid stays high when the next pixel follows at once
    task automatic send_pixel(input logic [23:0] px, input int gap);
        i_valid    <= 1'b1;
        i_blue_in  <= px[7:0];
        i_green_in <= px[15:8];
        i_red_in   <= px[23:16];
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_sharpened_pixels(px);
        pixels_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] make_pixel(input t_pattern pat, input int y, input int x);
        logic [23:0] px;
        px = '0;
        case (pat)
            PAT_NOISE: begin
                px = 24'($urandom);
            end
            PAT_BINARY: begin
                for (int ch = 0; ch < 3; ch++) begin
                    px[8*ch +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                end
            end
            PAT_SMOOTH: begin
                for (int ch = 0; ch < 3; ch++) begin
                    px[8*ch +: 8] = 8'(40 + 9 * x + 7 * y + 20 * ch + $urandom_range(0, 3));
                end
            end
            PAT_BARS: begin
                px = (x == 0) ? 24'h000000 : (x == 1) ? 24'h80ff01 : 24'hffffff;
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // up to pixel_limit pixels from the current frame position, then drain
    task automatic send_frame(input t_pattern pat, input int pixel_limit);
        int total;
        total = clamp_size(cfg_width) * clamp_size(cfg_height);
        if (pixel_limit < total) begin
            total = pixel_limit;
        end
        for (int n = 0; n < total; n++) begin
            send_pixel(make_pixel(pat, frame_row, frame_col), pick_gap());
        end
        wait_idle();
    endtask

    // all results in, then a drain pad for pixels that release nothing
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [11:0] w, input logic [11:0] h);
        write_register(sts_pkg::REG_IMAGE_WIDTH, w);
        write_register(sts_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // threshold and step, with random bits above the register width
    task automatic set_edge_rule(input logic [7:0] thr, input logic signed [8:0] step);
        write_register(sts_pkg::REG_EDGE_THRESHOLD, {4'($urandom), thr});
        write_register(sts_pkg::REG_BRIGHTNESS_STEP, {3'($urandom), step});
    endtask

    // ------------------------------------------------------------------
    // result side: random stall and the checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : stall_gen
        int roll;
        roll = $urandom_range(0, 99);
        if (!i_rst_n || out_quiet) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (roll < 65) begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else if (roll < 95) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(8, 30);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [10:0] got,
                               input logic [10:0] want, input t_out_pixel e);
        if (got !== want) begin
            report_mismatch($sformatf("%s at row %0d col %0d: got %0h, want %0h",
                                      name, e.row, e.col, got, want));
        end
    endtask

    // each output transaction against the oldest expected pixel
    always @(posedge i_clk) begin : pixel_checker
        t_out_pixel e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected output pixel row %0d col %0d",
                                          o_out_row, o_out_col));
            end else begin
                e = expected_pixels.pop_front();
                check_field("blue", 11'(o_blue_out), 11'(e.blue), e);
                check_field("green", 11'(o_green_out), 11'(e.green), e);
                check_field("red", 11'(o_red_out), 11'(e.red), e);
                check_field("row", o_out_row, e.row, e);
                check_field("col", o_out_col, e.col, e);
                check_field("last", 11'(o_last_of_run), 11'(e.last), e);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // height, threshold and step straight from reset; a narrow width keeps
    // the run short, and 480 rows means no bottom flush
    task automatic test_reset_registers();
        in_quiet  = 1'b1;
        out_quiet = 1'b0;
        write_register(sts_pkg::REG_IMAGE_WIDTH, 12'd5);
        send_frame(PAT_NOISE, 20);
        in_quiet  = 1'b0;
    endtask

    // 3x3 frame with one inner pixel: full steps both ways, threshold at its
    // ends, twice the threshold just under the bar edge magnitude (127), then binary pixels
    task automatic test_edge_extremes();
        set_frame_size(12'd3, 12'd3);
        set_edge_rule(8'd0, 9'sd255);
        send_frame(PAT_BARS, 9);
        set_edge_rule(8'd0, -9'sd255);
        send_frame(PAT_BARS, 9);
        set_edge_rule(8'd255, 9'sd255);
        send_frame(PAT_BARS, 9);
        set_edge_rule(8'd63, 9'sd1);
        send_frame(PAT_BARS, 9);
        set_edge_rule(8'd64, 9'sd1);
        send_frame(PAT_BINARY, 9);
    endtask

    // sizes below 3 and above 2048 saturate; the widest row stays inside
    // row 0, so nothing may come out
    task automatic test_size_limits();
        set_edge_rule(8'd4, 9'sd100);
        set_frame_size(12'd0, 12'd2);
        send_frame(PAT_NOISE, 9);
        set_frame_size(12'd1, 12'd0);
        send_frame(PAT_BINARY, 9);
        set_frame_size(12'hfff, 12'd3);
        send_frame(PAT_NOISE, 24);
    endtask

    // a size write in the middle of a frame starts over at row 0
    task automatic test_frame_restart();
        set_frame_size(12'd5, 12'd4);
        send_frame(PAT_NOISE, 7);
        write_register(sts_pkg::REG_IMAGE_HEIGHT, 12'd4);
        send_frame(PAT_BINARY, 20);
    endtask

    // mostly whole frames of random size and content; some cut short, some
    // with the edge rule changed between pixels
    task automatic test_random_frames();
        int       start;
        int       w;
        int       h;
        int       total;
        int       split;
        int       kind;
        t_pattern pat;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            in_quiet  = ($urandom_range(0, 4) == 0);
            out_quiet = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(3, 8);
            h = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(3, 6);
            set_frame_size(12'(w), 12'(h));
            set_edge_rule(($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 20))
                                                      : 8'($urandom),
                          9'($urandom_range(0, 510) - 255));
            pat   = t_pattern'($urandom_range(0, 3));
            total = w * h;
            kind  = $urandom_range(0, 9);
            split = $urandom_range(1, total - 1);
            if (kind == 0) begin
                // broken frame, the next size write restarts it
                send_frame(pat, split);
            end else if (kind == 1) begin
                send_frame(pat, split);
                set_edge_rule(8'($urandom_range(0, 12)), 9'($urandom_range(0, 510) - 255));
                send_frame(pat, total - split);
            end else begin
                send_frame(pat, total);
            end
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin : main
        int waited;
        foreach (line_store_above[i]) begin
            line_store_above[i]     = '0;
            line_store_two_above[i] = '0;
        end
        foreach (window_cols[i]) begin
            window_cols[i] = '0;
        end
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_edge_extremes();
        test_size_limits();
        test_frame_restart();
        test_random_frames();

        i_valid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d expected output pixels never arrived",
                                      expected_pixels.size()));
        end
        if (error_count == 0) begin
            $display("sobel_threshold_sharpen regression: pass");
        end else begin
            $display("sobel_threshold_sharpen regression: fail");
        end
        $finish;
    end

    // hang guard
    initial begin : run_limit
        #(LIMIT_TIME);
        $display("sobel_threshold_sharpen regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
